@@ rtl/deq_pkg.sv @@
// Shared types and codes for the double-ended queue core.
// Used by deq_cell and double_ended_queue_core; depends on nothing else.
package deq_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;
    localparam int OCC_W         = 5;

    localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
    localparam logic [1:0] ACT_PUSH_BACK  = 2'd1;
    localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
    localparam logic [1:0] ACT_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] NONE_VALUE = -32'sd1;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } t_out_word;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic       en;
        logic [1:0] action;
    } t_cell_ctrl;

endpackage

@@ rtl/deq_cell.sv @@
// One storage cell of the queue row: a value and an occupied flag.
// Depends on deq_pkg for the command struct and action codes.
module deq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  deq_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [deq_pkg::DATA_W-1:0] i_push_value,
    input  logic signed [deq_pkg::DATA_W-1:0] i_left_value,
    input  logic                              i_left_valid,
    input  logic signed [deq_pkg::DATA_W-1:0] i_right_value,
    input  logic                              i_right_valid,
    output logic signed [deq_pkg::DATA_W-1:0] o_value,
    output logic                              o_valid,
    output logic                              o_is_back
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] r_value, n_value;
    logic                     r_valid, n_valid;

    // The occupied cells always form a prefix of the row, so a cell is the
    // back entry when it is occupied and its right neighbor is not.
    assign o_is_back = r_valid && !i_right_valid;
    assign o_value   = r_value;
    assign o_valid   = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.en) begin
            unique case (i_ctrl.action)
                ACT_PUSH_FRONT: begin
                    n_value = i_left_value;
                    n_valid = i_left_valid;
                end
                ACT_PUSH_BACK: begin
                    if (!r_valid && i_left_valid) begin
                        n_value = i_push_value;
                        n_valid = 1'b1;
                    end
                end
                ACT_POP_FRONT: begin
                    n_value = i_right_value;
                    n_valid = i_right_valid;
                end
                ACT_POP_BACK: begin
                    if (o_is_back) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ rtl/double_ended_queue_core.sv @@
// Top level of the double-ended queue: a row of shifting cells plus the
// output word register. Depends on deq_pkg and deq_cell.
//
//  Channel  Signals                              Direction  Contents
//  in       i_in_valid, o_in_ready, i_in_word    into core  action, push value
//  out      o_out_valid, i_out_ready, o_out_word out of     popped value, status,
//                                                           occupancy
//
// For each word, the whole row of cells shifts or updates in the cycle it is
// accepted, and the result is registered for the next cycle.
// A new word is taken every cycle as long as the output register is empty or
// is being drained; a stall on the output holds the input ready low.
// Reset (synchronous, active low) empties the row and the output register;
// the cell values themselves are not cleared.
module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  deq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output deq_pkg::t_out_word o_out_word
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] w_value      [DEPTH];
    logic signed [DATA_W-1:0] w_left_value [DEPTH];
    logic signed [DATA_W-1:0] w_right_value[DEPTH];
    logic [DEPTH-1:0]         w_valid;
    logic [DEPTH-1:0]         w_left_valid;
    logic [DEPTH-1:0]         w_right_valid;
    logic [DEPTH-1:0]         w_is_back;

    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid;
    t_out_word                r_out_word, n_out_word;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_is_push;
    logic                     w_legal;
    logic signed [DATA_W-1:0] w_back_value;
    t_cell_ctrl               w_ctrl;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_is_push   = (i_in_word.action == ACT_PUSH_FRONT) ||
                         (i_in_word.action == ACT_PUSH_BACK);
    assign w_legal     = w_is_push ? !w_full : !w_empty;
    assign w_ctrl      = '{en: w_accept && w_legal, action: i_in_word.action};

    // Neighbor wiring: the front cell takes the push value from its left,
    // the last cell sees an empty neighbor on its right.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                w_left_value[i] = i_in_word.push_value;
                w_left_valid[i] = 1'b1;
            end else begin
                w_left_value[i] = w_value[i-1];
                w_left_valid[i] = w_valid[i-1];
            end
            if (i == DEPTH - 1) begin
                w_right_value[i] = w_value[i];
                w_right_valid[i] = 1'b0;
            end else begin
                w_right_value[i] = w_value[i+1];
                w_right_valid[i] = w_valid[i+1];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_push_value  (i_in_word.push_value),
            .i_left_value  (w_left_value[g]),
            .i_left_valid  (w_left_valid[g]),
            .i_right_value (w_right_value[g]),
            .i_right_valid (w_right_valid[g]),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_is_back     (w_is_back[g])
        );
    end

    // At most one cell flags itself as the back entry (none when the queue is
    // empty), so an OR of the masked values picks it out.
    always_comb begin
        w_back_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back_value = w_back_value | (w_value[i] & {DATA_W{w_is_back[i]}});
        end
    end

    always_comb begin
        n_count              = r_count;
        n_out_word.pop_value = NONE_VALUE;
        n_out_word.status    = ST_OK;
        if (w_is_push) begin
            if (w_full) begin
                n_out_word.status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_out_word.status = ST_EMPTY;
            end else begin
                n_count = r_count - CNT_W'(1);
                if (i_in_word.action == ACT_POP_FRONT) begin
                    n_out_word.pop_value = w_value[0];
                end else begin
                    n_out_word.pop_value = w_back_value;
                end
            end
        end
        n_out_word.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_count_matches_cells : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count)
    ) else $error("occupied cell count differs from the entry count");

    a_cells_form_prefix : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_is_back) && ((r_count == '0) == (w_is_back == '0))
    ) else $error("occupied cells do not form a single prefix");

    a_full_status : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_push && w_full) |=>
            (o_out_word.status == ST_FULL) && $stable(r_count)
    ) else $error("push to a full queue changed the state");

endmodule
